// ----- rtl/core/ppu_pkg.sv -----
`timescale 1ns / 1ps
// Package for the perspective point projection unit: widths, codes, structs
// and the one-bit divider step. No dependencies.
package ppu_pkg;

    localparam int MAT_WORDS = 12;
    localparam int IDX_W     = 4;
    localparam int FRAC      = 16;
    localparam int Q_W       = 50;              // signed row result, Q34.16
    localparam int M_W       = 49;              // magnitude / positive divisor
    localparam int HI_SH     = 33;              // magnitude bits streamed in
    localparam int QUO_W     = HI_SH + FRAC;    // quotient bits produced
    localparam int LIM_W     = 21;
    localparam int DIM_W     = 14;
    localparam int MRG_W     = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic [QUO_W-1:0] NDC_MAX = QUO_W'(64'd1 << 47);

    typedef logic signed [Q_W-1:0] t_q;

    typedef enum logic [2:0] {
        REJ_OK     = 3'd0,
        REJ_NEAR   = 3'd1,
        REJ_CLIP   = 3'd2,
        REJ_MARGIN = 3'd3,
        REJ_OVF    = 3'd4
    } t_rej;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_NEAR    = 3'd2,
        REG_CLIP_EN = 3'd3,
        REG_NDC_LIM = 3'd4,
        REG_MARGIN  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic near_rej;
        logic x_neg;
        logic y_neg;
        logic x_ovf;
        logic y_ovf;
    } t_side;

    typedef struct packed {
        logic [M_W-1:0]   rem;
        logic [QUO_W-1:0] num;
        logic [QUO_W-1:0] quo;
    } t_dlane;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    function automatic t_dlane div_step(t_dlane a, logic [M_W-1:0] d);
        logic [M_W:0] t;
        logic         ge;
        t_dlane       r;
        t     = {a.rem, a.num[QUO_W-1]};
        ge    = (t >= {1'b0, d});
        r.rem = ge ? M_W'(t - {1'b0, d}) : t[M_W-1:0];
        r.num = {a.num[QUO_W-2:0], 1'b0};
        r.quo = {a.quo[QUO_W-2:0], ge};
        return r;
    endfunction

endpackage

// ----- rtl/core/ppu_if.sv -----
`timescale 1ns / 1ps
// Request channels of the projection unit: point/load input, result output,
// register write. Depends on ppu_pkg.
interface ppu_pt_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [ppu_pkg::IDX_W-1:0]         coef_index;
    logic signed [31:0]                coef_value;
    logic signed [31:0]                point_x;
    logic signed [31:0]                point_y;
    logic signed [31:0]                point_z;
    modport source(output valid, action, coef_index, coef_value, point_x, point_y,
                   point_z, input ready);
    modport sink(input valid, action, coef_index, coef_value, point_x, point_y,
                 point_z, output ready);
endinterface

interface ppu_res_if;
    logic               valid;
    logic               ready;
    logic               visible;
    logic signed [31:0] pix_x;
    logic signed [31:0] pix_y;
    logic [2:0]         reject_code;
    modport source(output valid, visible, pix_x, pix_y, reject_code, input ready);
    modport sink(input valid, visible, pix_x, pix_y, reject_code, output ready);
endinterface

interface ppu_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ppu_pkg::CFG_IDX_W-1:0]     index;
    logic [ppu_pkg::LIM_W-1:0]         data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/ppu_xform.sv -----
`timescale 1ns / 1ps
// Matrix rows 0, 1 and 2 times the point: multiply stage, then sum stage.
// Depends on ppu_pkg.
module ppu_xform (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [31:0]     i_x,
    input  logic signed [31:0]     i_y,
    input  logic signed [31:0]     i_z,
    input  logic signed [31:0]     i_mat [ppu_pkg::MAT_WORDS],
    output logic                   o_valid,
    output ppu_pkg::t_q            o_qx,
    output ppu_pkg::t_q            o_qy,
    output ppu_pkg::t_q            o_qw
);
    logic               r_v1, r_v2;
    logic signed [63:0] r_prod [9];
    logic signed [31:0] r_off [3];
    ppu_pkg::t_q        r_q [3];
    logic signed [65:0] n_sum [3];
    ppu_pkg::t_q        n_q [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod[3*r]   <= i_x * i_mat[4*r];
                r_prod[3*r+1] <= i_y * i_mat[4*r+1];
                r_prod[3*r+2] <= i_z * i_mat[4*r+2];
                r_off[r]      <= i_mat[4*r+3];
                r_q[r]        <= n_q[r];
            end
        end
        always_comb begin
            n_sum[r] = 66'(r_prod[3*r]) + 66'(r_prod[3*r+1]) + 66'(r_prod[3*r+2]);
            n_q[r]   = ppu_pkg::t_q'(n_sum[r] >>> ppu_pkg::FRAC) + ppu_pkg::t_q'(r_off[r]);
        end
    end

    assign o_valid = r_v2;
    assign o_qx    = r_q[0];
    assign o_qy    = r_q[1];
    assign o_qw    = r_q[2];
endmodule

// ----- rtl/core/ppu_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing
// one divisor. Depends on ppu_pkg.
module ppu_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  ppu_pkg::t_side              i_side,
    input  ppu_pkg::t_dlane             i_lane_x,
    input  ppu_pkg::t_dlane             i_lane_y,
    input  logic [ppu_pkg::M_W-1:0]     i_dvs,
    output logic                        o_valid,
    output ppu_pkg::t_side              o_side,
    output logic [ppu_pkg::QUO_W-1:0]   o_qx,
    output logic [ppu_pkg::QUO_W-1:0]   o_qy
);
    localparam int DS = ppu_pkg::QUO_W;

    logic                      r_v  [DS];
    ppu_pkg::t_side            r_s  [DS];
    ppu_pkg::t_dlane           r_lx [DS];
    ppu_pkg::t_dlane           r_ly [DS];
    logic [ppu_pkg::M_W-1:0]   r_d  [DS];

    for (genvar k = 0; k < DS; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_s[k]  <= i_side;
                    r_d[k]  <= i_dvs;
                    r_lx[k] <= ppu_pkg::div_step(i_lane_x, i_dvs);
                    r_ly[k] <= ppu_pkg::div_step(i_lane_y, i_dvs);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_s[k]  <= r_s[k-1];
                    r_d[k]  <= r_d[k-1];
                    r_lx[k] <= ppu_pkg::div_step(r_lx[k-1], r_d[k-1]);
                    r_ly[k] <= ppu_pkg::div_step(r_ly[k-1], r_d[k-1]);
                end
            end
        end
    end

    assign o_valid = r_v[DS-1];
    assign o_side  = r_s[DS-1];
    assign o_qx    = r_lx[DS-1].quo;
    assign o_qy    = r_ly[DS-1].quo;
endmodule

// ----- rtl/core/ppu_map.sv -----
`timescale 1ns / 1ps
// Viewport mapping: clip and overflow codes with scale products, then
// offset, range and margin checks into the output register. Depends on ppu_pkg.
module ppu_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_ready,
    input  logic                        i_valid,
    input  ppu_pkg::t_side              i_side,
    input  logic [ppu_pkg::QUO_W-1:0]   i_mx,
    input  logic [ppu_pkg::QUO_W-1:0]   i_my,
    input  logic [ppu_pkg::DIM_W-1:0]   i_w,
    input  logic [ppu_pkg::DIM_W-1:0]   i_h,
    input  logic                        i_clip_en,
    input  logic [ppu_pkg::LIM_W-1:0]   i_lim,
    input  logic [ppu_pkg::MRG_W-1:0]   i_margin,
    output logic                        o_en,
    output logic                        o_valid,
    output logic                        o_visible,
    output logic signed [31:0]          o_sx,
    output logic signed [31:0]          o_sy,
    output ppu_pkg::t_rej               o_code
);
    localparam logic signed [65:0] S_MIN = -(66'sd1 <<< 31);
    localparam logic signed [65:0] S_MAX = (66'sd1 <<< 31) - 66'sd1;

    logic               r_a_v, r_out_v, r_vis;
    ppu_pkg::t_rej      r_a_code, r_code, n_a_code, n_code;
    logic signed [63:0] r_pw, r_ph;
    logic signed [31:0] r_sx, r_sy;
    logic signed [49:0] n_nx, n_ny;
    logic signed [65:0] n_sx, n_sy, n_mg, n_xhi, n_yhi;
    logic               n_big, n_clip, n_rng, n_mrg;

    assign o_en = !r_out_v || i_ready;

    always_comb begin
        n_big  = i_side.x_ovf || i_side.y_ovf;
        n_clip = n_big || (i_mx > ppu_pkg::QUO_W'(i_lim)) || (i_my > ppu_pkg::QUO_W'(i_lim));
        n_nx   = i_side.x_neg ? -$signed({1'b0, i_mx}) : $signed({1'b0, i_mx});
        n_ny   = i_side.y_neg ? -$signed({1'b0, i_my}) : $signed({1'b0, i_my});
        priority if (i_side.near_rej) begin
            n_a_code = ppu_pkg::REJ_NEAR;
        end else if (i_clip_en && n_clip) begin
            n_a_code = ppu_pkg::REJ_CLIP;
        end else if (n_big || i_mx > ppu_pkg::NDC_MAX || i_my > ppu_pkg::NDC_MAX) begin
            n_a_code = ppu_pkg::REJ_OVF;
        end else begin
            n_a_code = ppu_pkg::REJ_OK;
        end
    end

    always_comb begin
        n_sx  = 66'(r_pw >>> 1) + $signed(66'({1'b0, i_w, 15'b0}));
        n_sy  = 66'((-r_ph) >>> 1) + $signed(66'({1'b0, i_h, 15'b0}));
        n_mg  = $signed(66'({1'b0, i_margin, 16'b0}));
        n_xhi = $signed(66'({1'b0, i_w, 16'b0})) + n_mg;
        n_yhi = $signed(66'({1'b0, i_h, 16'b0})) + n_mg;
        n_rng = (n_sx < S_MIN) || (n_sx > S_MAX) || (n_sy < S_MIN) || (n_sy > S_MAX);
        n_mrg = (n_sx < -n_mg) || (n_sy < -n_mg) || (n_sx > n_xhi) || (n_sy > n_yhi);
        priority if (r_a_code != ppu_pkg::REJ_OK) begin
            n_code = r_a_code;
        end else if (n_rng) begin
            n_code = ppu_pkg::REJ_OVF;
        end else if (n_mrg) begin
            n_code = ppu_pkg::REJ_MARGIN;
        end else begin
            n_code = ppu_pkg::REJ_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (o_en) begin
            r_a_v   <= i_valid;
            r_out_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_a_code <= n_a_code;
            r_pw     <= $signed({1'b0, i_w}) * n_nx;
            r_ph     <= $signed({1'b0, i_h}) * n_ny;
            r_code   <= n_code;
            r_vis    <= (n_code == ppu_pkg::REJ_OK);
            r_sx     <= (n_code == ppu_pkg::REJ_OK) ? n_sx[31:0] : '0;
            r_sy     <= (n_code == ppu_pkg::REJ_OK) ? n_sy[31:0] : '0;
        end
    end

    assign o_valid   = r_out_v;
    assign o_visible = r_vis;
    assign o_sx      = r_sx;
    assign o_sy      = r_sy;
    assign o_code    = r_code;
endmodule

// ----- rtl/core/perspective_point_projection_unit.sv -----
`timescale 1ns / 1ps
// Perspective point projection unit: 2 transform stages, 49 divider stages
// and 2 mapping stages from point request to result. Throughput: one
// request per cycle while the result output is not stalled; the 49-stage
// bit-per-stage divider sets the depth. Loads write the matrix at acceptance
// and produce no result. Reset (synchronous, active low) clears valid bits
// and restores the registers; matrix words stay undefined until loaded.
module perspective_point_projection_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppu_pt_if.sink      i_pt,
    ppu_res_if.source   o_res,
    ppu_cfg_if.sink     i_cfg
);
    // configuration registers
    logic [ppu_pkg::DIM_W-1:0] r_width, r_height;
    logic [ppu_pkg::LIM_W-1:0] r_near, r_ndc_lim;
    logic                      r_clip_en;
    logic [ppu_pkg::MRG_W-1:0] r_margin;

    // matrix words, written by load requests
    logic signed [31:0] r_mat [ppu_pkg::MAT_WORDS];

    logic                            w_en, w_acc;
    logic                            w_xv, w_dv;
    ppu_pkg::t_q                     w_qx, w_qy, w_qw, w_negx, w_negy;
    logic [ppu_pkg::M_W-1:0]         w_magx, w_magy, w_hix, w_hiy;
    ppu_pkg::t_side                  w_side, w_dside;
    ppu_pkg::t_dlane                 w_lx, w_ly;
    logic [ppu_pkg::QUO_W-1:0]       w_mx, w_my;
    ppu_pkg::t_rej                   w_code;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= ppu_pkg::DIM_W'(1920);
            r_height  <= ppu_pkg::DIM_W'(1080);
            r_near    <= ppu_pkg::LIM_W'(6554);
            r_clip_en <= 1'b0;
            r_ndc_lim <= ppu_pkg::LIM_W'(88474);
            r_margin  <= ppu_pkg::MRG_W'(200);
        end else if (i_cfg.valid) begin
            unique case (ppu_pkg::t_reg_idx'(i_cfg.index))
                ppu_pkg::REG_WIDTH:   r_width   <= i_cfg.data[ppu_pkg::DIM_W-1:0];
                ppu_pkg::REG_HEIGHT:  r_height  <= i_cfg.data[ppu_pkg::DIM_W-1:0];
                ppu_pkg::REG_NEAR:    r_near    <= i_cfg.data;
                ppu_pkg::REG_CLIP_EN: r_clip_en <= i_cfg.data[0];
                ppu_pkg::REG_NDC_LIM: r_ndc_lim <= i_cfg.data;
                ppu_pkg::REG_MARGIN:  r_margin  <= i_cfg.data[ppu_pkg::MRG_W-1:0];
                default: ;
            endcase
        end
    end

    // the whole pipeline advances together whenever the output slot frees up
    assign i_pt.ready = w_en;
    assign w_acc      = i_pt.valid && i_pt.ready;

    // load: drop writes to slots past the last word
    always_ff @(posedge i_clk) begin
        if (w_acc && !i_pt.action &&
            (i_pt.coef_index < ppu_pkg::IDX_W'(ppu_pkg::MAT_WORDS))) begin
            r_mat[i_pt.coef_index] <= i_pt.coef_value;
        end
    end

    ppu_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_acc && i_pt.action),
        .i_x     (i_pt.point_x),
        .i_y     (i_pt.point_y),
        .i_z     (i_pt.point_z),
        .i_mat   (r_mat),
        .o_valid (w_xv),
        .o_qx    (w_qx),
        .o_qy    (w_qy),
        .o_qw    (w_qw)
    );

    // Set up the divider: magnitudes, near test, and the quotient-too-large
    // check (|q|*2^16 >= qw*2^49 means the normalized value is far beyond range).
    always_comb begin
        w_negx          = -w_qx;
        w_negy          = -w_qy;
        w_magx          = w_qx[ppu_pkg::Q_W-1] ? w_negx[ppu_pkg::M_W-1:0] : w_qx[ppu_pkg::M_W-1:0];
        w_magy          = w_qy[ppu_pkg::Q_W-1] ? w_negy[ppu_pkg::M_W-1:0] : w_qy[ppu_pkg::M_W-1:0];
        w_hix           = w_magx >> ppu_pkg::HI_SH;
        w_hiy           = w_magy >> ppu_pkg::HI_SH;
        w_side.near_rej = (w_qw <= 0) || (w_qw < ppu_pkg::t_q'({1'b0, r_near}));
        w_side.x_neg    = w_qx[ppu_pkg::Q_W-1];
        w_side.y_neg    = w_qy[ppu_pkg::Q_W-1];
        w_side.x_ovf    = (w_hix >= w_qw[ppu_pkg::M_W-1:0]);
        w_side.y_ovf    = (w_hiy >= w_qw[ppu_pkg::M_W-1:0]);
        w_lx.rem        = w_hix;
        w_lx.num        = {w_magx[ppu_pkg::HI_SH-1:0], ppu_pkg::FRAC'(0)};
        w_lx.quo        = '0;
        w_ly.rem        = w_hiy;
        w_ly.num        = {w_magy[ppu_pkg::HI_SH-1:0], ppu_pkg::FRAC'(0)};
        w_ly.quo        = '0;
    end

    ppu_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_xv),
        .i_side   (w_side),
        .i_lane_x (w_lx),
        .i_lane_y (w_ly),
        .i_dvs    (w_qw[ppu_pkg::M_W-1:0]),
        .o_valid  (w_dv),
        .o_side   (w_dside),
        .o_qx     (w_mx),
        .o_qy     (w_my)
    );

    ppu_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ready   (o_res.ready),
        .i_valid   (w_dv),
        .i_side    (w_dside),
        .i_mx      (w_mx),
        .i_my      (w_my),
        .i_w       (r_width),
        .i_h       (r_height),
        .i_clip_en (r_clip_en),
        .i_lim     (r_ndc_lim),
        .i_margin  (r_margin),
        .o_en      (w_en),
        .o_valid   (o_res.valid),
        .o_visible (o_res.visible),
        .o_sx      (o_res.pix_x),
        .o_sy      (o_res.pix_y),
        .o_code    (w_code)
    );

    assign o_res.reject_code = w_code;

    a_vis_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.visible == (o_res.reject_code == ppu_pkg::REJ_OK)))
        else $error("visible disagrees with reject code");

    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.visible) |-> (o_res.pix_x == 0 && o_res.pix_y == 0))
        else $error("rejected point carries nonzero coordinates");

    a_code_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.reject_code <= ppu_pkg::REJ_OVF))
        else $error("reject code out of range");
endmodule
